/* src/wrpf_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed radius point filter package
// Shared widths, codes and structures for the point filter lanes and merge.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpf_pkg;

  localparam int unsigned COORD_W            = 16;
  localparam int unsigned NUM_COORDS         = 3;
  localparam int unsigned SLOT_W             = 16;
  localparam int unsigned MAX_DIMS           = 4;
  localparam int unsigned VEC_W              = 48;
  localparam int unsigned VEC_EXT_W          = SLOT_W * MAX_DIMS;
  localparam int unsigned DIST_W             = 34;
  localparam int unsigned SQ_W               = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = VEC_W;
  localparam int unsigned DIMS_DEFAULT       = 3;
  localparam int unsigned COORD_BITS_DEFAULT = 16;

  localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] RADIUS_HIGH_RST = 34'd12884508675;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_HIGH = 3'd4;

  localparam int unsigned PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WINDOW = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            ge_lower;
    logic            gt_upper;
  } lane_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic              at_lower;
    logic              past_upper;
  } merge_t;

endpackage

`default_nettype wire

/* src/wrpf_lane.sv */
// ----------------------------------------------------------------------------
// Point filter lane
// One dimension: absolute difference to the centre, its square and the two
// window corner compares, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpf_lane #(
  parameter int unsigned COORD_BITS = wrpf_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [COORD_BITS-1:0] coord_i,
  input  wire logic [COORD_BITS-1:0] center_i,
  input  wire logic [COORD_BITS-1:0] lower_i,
  input  wire logic [COORD_BITS-1:0] upper_i,
  output wrpf_pkg::lane_t            res_o
);
  import wrpf_pkg::*;

  logic [COORD_BITS-1:0]   diff;
  logic [2*COORD_BITS-1:0] prod;
  lane_t                   res_d;
  lane_t                   res_q;

  always_comb begin
    diff           = (coord_i >= center_i) ? (coord_i - center_i) : (center_i - coord_i);
    prod           = diff * diff;
    res_d.sq       = SQ_W'(prod);
    res_d.ge_lower = (coord_i >= lower_i);
    res_d.gt_upper = (coord_i > upper_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* src/wrpf_merge.sv */
// ----------------------------------------------------------------------------
// Point filter merge
// Sums the lane squares with saturation and combines the corner flags.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpf_merge #(
  parameter int unsigned DIMS = wrpf_pkg::DIMS_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire wrpf_pkg::lane_t   lanes_i [DIMS],
  output wrpf_pkg::merge_t       res_o
);
  import wrpf_pkg::*;

  logic [DIST_W:0] sum;
  merge_t          res_d;
  merge_t          res_q;

  always_comb begin
    sum              = '0;
    res_d.at_lower   = 1'b1;
    res_d.past_upper = 1'b1;
    for (int unsigned l = 0; l < DIMS; l++) begin
      sum              = sum + (DIST_W + 1)'(lanes_i[l].sq);
      res_d.at_lower   = res_d.at_lower & lanes_i[l].ge_lower;
      res_d.past_upper = res_d.past_upper & lanes_i[l].gt_upper;
    end
    res_d.dist_sq = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* src/windowed_radius_point_filter.sv */
// ----------------------------------------------------------------------------
// Windowed radius point filter
// Streams lattice points through a scan window and passes on those whose
// squared distance to the centre lies within an inclusive annulus, and every last point.
//
//   Channel   Handshake               Payload
//   input     in_valid_i/in_ready_o   coord_0_i..coord_2_i, in_last_i
//   output    out_valid_o/out_ready_i hit_o, out_coord_*_o, dist_sq_o, scan_end_o
//   config    cfg_we_i                cfg_idx_i, cfg_data_i
//
// One word is taken every cycle while the pipeline is not halted; each word passes
// the registers in order: lane square, merge sum, then phase and output register.
// The whole pipeline halts while the output register holds an untaken word.
// Reset returns the scan phase to skipping and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_radius_point_filter #(
  parameter int unsigned DIMS       = wrpf_pkg::DIMS_DEFAULT,
  parameter int unsigned COORD_BITS = wrpf_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wrpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [wrpf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [wrpf_pkg::COORD_W-1:0]        coord_0_i,
  input  wire logic [wrpf_pkg::COORD_W-1:0]        coord_1_i,
  input  wire logic [wrpf_pkg::COORD_W-1:0]        coord_2_i,
  input  wire logic                                in_last_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic                                hit_o,
  output      logic [wrpf_pkg::COORD_W-1:0]        out_coord_0_o,
  output      logic [wrpf_pkg::COORD_W-1:0]        out_coord_1_o,
  output      logic [wrpf_pkg::COORD_W-1:0]        out_coord_2_o,
  output      logic [wrpf_pkg::DIST_W-1:0]         dist_sq_o,
  output      logic                                scan_end_o
);
  import wrpf_pkg::*;

  logic [VEC_W-1:0]  center_q, lower_q, upper_q;
  logic [DIST_W-1:0] radius_low_q, radius_high_q;

  logic [VEC_EXT_W-1:0] center_ext, lower_ext, upper_ext;
  logic [COORD_W-1:0]   in_coord [MAX_DIMS];

  logic adv;

  logic               s0_valid_q, s0_last_q;
  logic [COORD_W-1:0] s0_coord_q [NUM_COORDS];
  logic               s1_valid_q, s1_last_q;
  logic [COORD_W-1:0] s1_coord_q [NUM_COORDS];

  lane_t  lane_res [DIMS];
  merge_t merge_res;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               hit_d;

  logic               out_valid_q;
  logic               hit_q, scan_end_q;
  logic [COORD_W-1:0] out_coord_q [NUM_COORDS];
  logic [DIST_W-1:0]  dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q      <= '0;
      lower_q       <= '0;
      upper_q       <= {VEC_W{1'b1}};
      radius_low_q  <= '0;
      radius_high_q <= RADIUS_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER:      center_q      <= cfg_data_i;
        CFG_LOWER:       lower_q       <= cfg_data_i;
        CFG_UPPER:       upper_q       <= cfg_data_i;
        CFG_RADIUS_LOW:  radius_low_q  <= cfg_data_i[DIST_W-1:0];
        CFG_RADIUS_HIGH: radius_high_q <= cfg_data_i[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign center_ext  = VEC_EXT_W'(center_q);
  assign lower_ext   = VEC_EXT_W'(lower_q);
  assign upper_ext   = VEC_EXT_W'(upper_q);
  assign in_coord[0] = coord_0_i;
  assign in_coord[1] = coord_1_i;
  assign in_coord[2] = coord_2_i;
  assign in_coord[3] = '0;

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    wrpf_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .coord_i  (in_coord[d][COORD_BITS-1:0]),
      .center_i (center_ext[d*SLOT_W +: COORD_BITS]),
      .lower_i  (lower_ext[d*SLOT_W +: COORD_BITS]),
      .upper_i  (upper_ext[d*SLOT_W +: COORD_BITS]),
      .res_o    (lane_res[d])
    );
  end

  wrpf_merge #(
    .DIMS (DIMS)
  ) u_merge (
    .clk_i   (clk_i),
    .en_i    (adv),
    .lanes_i (lane_res),
    .res_o   (merge_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_SKIP;
    end else if (adv) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q;
      out_valid_q <= s1_valid_q && (hit_d || s1_last_q);
      if (s1_valid_q) begin
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_last_q     <= in_last_i;
      s0_coord_q[0] <= coord_0_i;
      s0_coord_q[1] <= coord_1_i;
      s0_coord_q[2] <= coord_2_i;
      s1_last_q     <= s0_last_q;
      s1_coord_q    <= s0_coord_q;
      hit_q         <= hit_d;
      scan_end_q    <= s1_last_q;
      out_coord_q   <= s1_coord_q;
      dist_q        <= merge_res.dist_sq;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hit_d   = 1'b0;
    if (phase_d == PH_SKIP && merge_res.at_lower) begin
      phase_d = PH_WINDOW;
    end
    if (phase_d == PH_WINDOW) begin
      if (merge_res.past_upper) begin
        phase_d = PH_DONE;
      end else begin
        hit_d = (merge_res.dist_sq >= radius_low_q) && (merge_res.dist_sq <= radius_high_q);
      end
    end
    if (s1_last_q) begin
      phase_d = PH_SKIP;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign scan_end_o    = scan_end_q;
  assign out_coord_0_o = out_coord_q[0];
  assign out_coord_1_o = out_coord_q[1];
  assign out_coord_2_o = out_coord_q[2];
  assign dist_sq_o     = dist_q;

  a_last_gives_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && s1_last_q) |=> (out_valid_o && scan_end_o))
    else $error("Last point did not produce an end word.");

  a_plain_word_is_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !scan_end_o) |-> hit_o)
    else $error("Word without end flag and without hit.");

  a_last_resets_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && s1_last_q) |=> (phase_q == PH_SKIP))
    else $error("Scan phase not returned to skipping after last point.");

  a_done_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE || phase_q == PH_SKIP))
    else $error("Finished scan reopened its window.");

  a_hit_in_annulus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (dist_sq_o >= radius_low_q && dist_sq_o <= radius_high_q))
    else $error("Hit outside the configured annulus.");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Windowed radius point filter testbench
// Streams lattice points through the filter while both handshakes idle at
// random. Two short directed tables come first, then lists of points built
// around randomly chosen windows and centres. Every accepted result word is
// compared field by field with the word that a typed table row or an independent
// predictor of the scan phase and the annulus test expects.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wrpf_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       z;
    logic [DIST_W-1:0] dist_sq;
    logic              scan_end;
  } hit_word_t;

  typedef struct packed {
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       z;
    logic              is_last;
    logic              typed;
    logic              t_hit;
    logic [DIST_W-1:0] t_dist;
  } probe_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_CENTER;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [COORD_W-1:0]    coord_0_i = '0;
  logic [COORD_W-1:0]    coord_1_i = '0;
  logic [COORD_W-1:0]    coord_2_i = '0;
  logic                  in_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [COORD_W-1:0]    out_coord_0_o;
  logic [COORD_W-1:0]    out_coord_1_o;
  logic [COORD_W-1:0]    out_coord_2_o;
  logic [DIST_W-1:0]     dist_sq_o;
  logic                  scan_end_o;

  windowed_radius_point_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_0_i     (coord_0_i),
    .coord_1_i     (coord_1_i),
    .coord_2_i     (coord_2_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .out_coord_0_o (out_coord_0_o),
    .out_coord_1_o (out_coord_1_o),
    .out_coord_2_o (out_coord_2_o),
    .dist_sq_o     (dist_sq_o),
    .scan_end_o    (scan_end_o)
  );

  // Predictor copy of the registers and the scan phase.
  logic [VEC_W-1:0]   ctr_vec = '0;
  logic [VEC_W-1:0]   low_vec = '0;
  logic [VEC_W-1:0]   high_vec = '1;
  logic [DIST_W-1:0]  r_lo = '0;
  logic [DIST_W-1:0]  r_hi = RADIUS_HIGH_RST;
  logic [PHASE_W-1:0] scan_state = PH_SKIP;

  hit_word_t pending_hits[$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;
  int        hold_asks = 0;

  // Under the reset settings every point lies in the window and the annulus.
  probe_row_t boot_rows [4] = '{
    '{16'd0,     16'd0,     16'd0,     1'b0, 1'b1, 1'b1, 34'd0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b1, 1'b1, 34'd12884508675},
    '{16'd1,     16'd2,     16'd3,     1'b1, 1'b1, 1'b1, 34'd14},
    '{16'd0,     16'd0,     16'd0,     1'b1, 1'b1, 1'b1, 34'd0}
  };

  // Centre (1000, 2000, 3000), window 900..1100 and so on, annulus 100..10000.
  probe_row_t window_rows [16] = '{
    '{16'd899,  16'd1900, 16'd2900, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1000, 16'd1899, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1010, 16'd2000, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1009, 16'd2000, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1100, 16'd2000, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1100, 16'd2001, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1000, 16'd2000, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1101, 16'd2101, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1050, 16'd2050, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1101, 16'd2101, 16'd3101, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1000, 16'd2010, 16'd3000, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1000, 16'd2010, 16'd3000, 1'b1, 1'b0, 1'b0, 34'd0},
    '{16'd950,  16'd1950, 16'd2950, 1'b1, 1'b0, 1'b0, 34'd0},
    '{16'd0,    16'd0,    16'd0,    1'b1, 1'b0, 1'b0, 34'd0},
    '{16'd1200, 16'd2200, 16'd3200, 1'b0, 1'b0, 1'b0, 34'd0},
    '{16'd1000, 16'd2000, 16'd3010, 1'b1, 1'b0, 1'b0, 34'd0}
  };

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] clip(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return 16'(v);
  endfunction

  function automatic bit judge_point(input logic [15:0] x, y, z, input logic is_last,
                                     output hit_word_t w);
    logic [15:0] p [3];
    logic [15:0] c;
    logic [15:0] diff;
    logic [35:0] acc;
    logic        reached;
    logic        beyond;
    logic        hit;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    acc = '0;
    reached = 1'b1;
    beyond = 1'b1;
    hit = 1'b0;
    for (int d = 0; d < NUM_COORDS; d++) begin
      c = ctr_vec[16*d +: 16];
      diff = (p[d] >= c) ? p[d] - c : c - p[d];
      acc = acc + 36'(diff) * 36'(diff);
      if (p[d] < low_vec[16*d +: 16]) reached = 1'b0;
      if (p[d] <= high_vec[16*d +: 16]) beyond = 1'b0;
    end
    if (acc > 36'(DIST_MAX)) acc = 36'(DIST_MAX);
    if (scan_state == PH_SKIP && reached) scan_state = PH_WINDOW;
    if (scan_state == PH_WINDOW) begin
      if (beyond) begin
        scan_state = PH_DONE;
      end else begin
        hit = (acc[DIST_W-1:0] >= r_lo) && (acc[DIST_W-1:0] <= r_hi);
      end
    end
    if (is_last) scan_state = PH_SKIP;
    w = '{hit, x, y, z, acc[DIST_W-1:0], is_last};
    return hit || is_last;
  endfunction

  task automatic note_mismatch(input string what, input logic [47:0] got, want);
    mismatches++;
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
  endtask

  task automatic offer_point(input logic [15:0] x, y, z, input logic is_last,
                             input logic typed, t_hit, input logic [DIST_W-1:0] t_dist);
    hit_word_t w;
    bit        has;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_0_i <= x;
    coord_1_i <= y;
    coord_2_i <= z;
    in_last_i <= is_last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has = judge_point(x, y, z, is_last, w);
    if (typed) begin
      w = '{t_hit, x, y, z, t_dist, is_last};
    end
    if (typed || has) begin
      pending_hits = {pending_hits, w};
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VEC_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [VEC_W-1:0] ctr, lo, hi, rlo, rhi);
    put_reg(CFG_CENTER, ctr);
    put_reg(CFG_LOWER, lo);
    put_reg(CFG_UPPER, hi);
    put_reg(CFG_RADIUS_LOW, rlo);
    put_reg(CFG_RADIUS_HIGH, rhi);
    cfg_we_i <= 1'b0;
    ctr_vec = ctr;
    low_vec = lo;
    high_vec = hi;
    r_lo = rlo[DIST_W-1:0];
    r_hi = rhi[DIST_W-1:0];
  endtask

  task automatic settle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_hits.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly well-formed point lists: a few points short of the lower corner,
  // then points around the centre, sometimes one beyond the upper corner.
  task automatic stream_lists(input int budget, input int unsigned span);
    int          sent;
    int          len;
    int          n_pre;
    int          done_at;
    logic [15:0] pt [3];
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 20) begin
        offer_point(16'($urandom), 16'($urandom), 16'($urandom),
                    $urandom_range(7) == 0, 1'b0, 1'b0, '0);
        sent++;
      end else begin
        len = int'($urandom_range(1, 16));
        n_pre = int'($urandom_range(0, 2));
        done_at = ($urandom_range(3) == 0) ? int'($urandom_range(0, len - 1)) : len;
        for (int k = 0; k < len; k++) begin
          for (int d = 0; d < NUM_COORDS; d++) begin
            if (k < n_pre && d == k % NUM_COORDS) begin
              pt[d] = clip(int'(low_vec[16*d +: 16]) - int'($urandom_range(1, 60)));
            end else if (k == done_at) begin
              pt[d] = clip(int'(high_vec[16*d +: 16]) + int'($urandom_range(1, 60)));
            end else begin
              pt[d] = clip(int'(ctr_vec[16*d +: 16]) + int'($urandom_range(0, 2 * span))
                           - int'(span));
            end
          end
          offer_point(pt[0], pt[1], pt[2], k == len - 1, 1'b0, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    hit_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        note_mismatch("unexpected word", 48'(dist_sq_o), '0);
      end else begin
        want = pending_hits.pop_front();
        if (hit_o !== want.hit) note_mismatch("hit", 48'(hit_o), 48'(want.hit));
        if (out_coord_0_o !== want.x) note_mismatch("coord 0", 48'(out_coord_0_o), 48'(want.x));
        if (out_coord_1_o !== want.y) note_mismatch("coord 1", 48'(out_coord_1_o), 48'(want.y));
        if (out_coord_2_o !== want.z) note_mismatch("coord 2", 48'(out_coord_2_o), 48'(want.z));
        if (dist_sq_o !== want.dist_sq) begin
          note_mismatch("dist_sq", 48'(dist_sq_o), 48'(want.dist_sq));
        end
        if (scan_end_o !== want.scan_end) begin
          note_mismatch("scan_end", 48'(scan_end_o), 48'(want.scan_end));
        end
      end
    end
  end

  always @(posedge clk_i) begin : drain_results
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on) begin
      out_ready_i <= ($urandom_range(99) >= 30);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [VEC_W-1:0] ctr;
    logic [VEC_W-1:0] lo;
    logic [VEC_W-1:0] hi;
    logic [VEC_W-1:0] rlo;
    logic [VEC_W-1:0] rhi;
    logic [VEC_W-1:0] tmp;
    int unsigned      span;
    int unsigned      cv;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (boot_rows[i]) begin
      offer_point(boot_rows[i].x, boot_rows[i].y, boot_rows[i].z, boot_rows[i].is_last,
                  boot_rows[i].typed, boot_rows[i].t_hit, boot_rows[i].t_dist);
    end
    settle();
    load_setting({16'd3000, 16'd2000, 16'd1000}, {16'd2900, 16'd1900, 16'd900},
                 {16'd3100, 16'd2100, 16'd1100}, 48'd100, 48'd10000);
    foreach (window_rows[i]) begin
      offer_point(window_rows[i].x, window_rows[i].y, window_rows[i].z,
                  window_rows[i].is_last, window_rows[i].typed, window_rows[i].t_hit,
                  window_rows[i].t_dist);
    end

    for (int p = 0; p < 10; p++) begin
      settle();
      idle_on = (p != 4);
      span = $urandom_range(1, 400);
      for (int d = 0; d < NUM_COORDS; d++) begin
        cv = $urandom_range(span, 65535 - span);
        ctr[16*d +: 16] = 16'(cv);
        lo[16*d +: 16] = 16'(cv - $urandom_range(0, span));
        hi[16*d +: 16] = 16'(cv + $urandom_range(0, span));
      end
      rhi = 48'($urandom_range(0, 3 * span * span));
      rlo = (p == 6) ? '0 : 48'($urandom_range(0, 32'(rhi)));
      case (p)
        0: begin
          span = 2;
          load_setting('0, '0, '0, '0, '0);
        end
        1: begin
          span = 2;
          load_setting('1, '1, '1, '1, '1);
        end
        3: begin
          // Every point hits, so the stalled receiver backs the pipe up.
          load_setting(ctr, '0, '1, '0, '1);
          hold_asks++;
        end
        5: begin
          tmp = lo;
          load_setting(ctr, hi, tmp, rlo, rhi);
        end
        7: begin
          load_setting(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                       48'({$urandom, $urandom}));
        end
        default: begin
          load_setting(ctr, lo, hi, rlo, rhi);
        end
      endcase
      stream_lists(60, span);
    end

    settle();
    if (pending_hits.size() != 0) begin
      note_mismatch("words never seen", 48'(pending_hits.size()), '0);
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/wrpf_pkg.sv
src/wrpf_lane.sv
src/wrpf_merge.sv
src/windowed_radius_point_filter.sv
bench/tb_top.sv
